### rtl/core/polyphonic_dds_tone_mixer_top_assert.svh
// ----------------------------------------------------------------------------
// Tone mixer assertion macros
// Concurrent assertion helpers for the tone mixer, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_DDS_TONE_MIXER_TOP_ASSERT_SVH
`define POLYPHONIC_DDS_TONE_MIXER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PDTM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tone mixer assertion failed");
`define PDTM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tone mixer assertion failed");
`else
`define PDTM_ASSERT_SAME(lbl, ante, cons)
`define PDTM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/pdtm_pkg.sv
// ----------------------------------------------------------------------------
// Tone mixer package
// Shared types, register codes, sine table and reciprocal table.
// ----------------------------------------------------------------------------
package pdtm_pkg;

   localparam int PACKED_VOICES = 4;
   localparam int VOICE_W       = 2;
   localparam int STEP_W        = 16;
   localparam int VOL_W         = 8;
   localparam int SAMPLE_W      = 8;
   localparam int ROM_IDX_W     = 8;
   localparam int ROM_DEPTH     = 256;
   localparam int COUNT_W       = 3;
   localparam int MUL_W         = 13;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int ACC_W         = 11;
   localparam int RECIP_SHIFT   = 11;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 64;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_VOICE_COUNT   = 2'd0,
      CSR_PHASE_STEPS   = 2'd1,
      CSR_VOICE_VOLUMES = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               accept;
      logic               advance;
      logic               mul_en;
      logic               mul_div;
      logic               acc_clr;
      logic               acc_en;
      logic               out_load;
      logic [VOICE_W-1:0] voice;
   } ctl_type;

   localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
      8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
      8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
      8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
      8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
      8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
      8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
      8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
      8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
      8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
      8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
      8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
      8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
      8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
      8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
      8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
      8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
      8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
      8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
      8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
      8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
      8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
      8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
      8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
      8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
      8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
      8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
      8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
      8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
      8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
      8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
   };

   // Reciprocals scaled by two to the RECIP_SHIFT; the thirds entry is
   // rounded up, which stays exact for every sum magnitude the mix reaches.
   function automatic logic [MUL_W-1:0] recip(input logic [COUNT_W-1:0] n);
      logic [MUL_W-1:0] r;
      unique case (n)
         3'd2:    r = 13'd1024;
         3'd3:    r = 13'd683;
         3'd4:    r = 13'd512;
         default: r = 13'd2048;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/pdtm_mul_unit.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused for every voice
// scaling and for the final divide by the voice count.
// ----------------------------------------------------------------------------
module pdtm_mul_unit (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [pdtm_pkg::MUL_W-1:0]   operand_a,
   input  logic signed [pdtm_pkg::MUL_W-1:0]   operand_b,
   output logic signed [pdtm_pkg::PROD_W-1:0]  product
);

   logic signed [pdtm_pkg::PROD_W-1:0] prod_ff;
   logic signed [pdtm_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = enable ? operand_a * operand_b : prod_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

### rtl/core/pdtm_phase_bank.sv
// ----------------------------------------------------------------------------
// Voice phase bank
// Holds the phase accumulator of each voice, clears and advances them, and
// looks up the sine sample of the selected voice.
// ----------------------------------------------------------------------------
module pdtm_phase_bank #(
   parameter int NUM_VOICES          = 4,
   parameter int TABLE_ENTRIES       = 256,
   parameter int PHASE_FRACTION_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             advance,
   input  logic [pdtm_pkg::VOICE_W-1:0]     voice,
   input  logic [pdtm_pkg::STEP_W-1:0]      step,
   output logic [pdtm_pkg::SAMPLE_W-1:0]    sample
);

   localparam int INT_W   = $clog2(TABLE_ENTRIES);
   localparam int PHASE_W = INT_W + PHASE_FRACTION_BITS;
   localparam int SUM_W   = (PHASE_W > pdtm_pkg::STEP_W) ? PHASE_W : pdtm_pkg::STEP_W;
   localparam int SEL_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   logic [PHASE_W-1:0]              phase_ff [NUM_VOICES];
   logic [PHASE_W-1:0]              phase_in [NUM_VOICES];
   logic [SEL_W-1:0]                sel;
   logic [PHASE_W-1:0]              cur_phase;
   logic [SUM_W-1:0]                phase_sum;
   logic [INT_W-1:0]                int_part;
   logic [INT_W+pdtm_pkg::ROM_IDX_W-1:0] scaled;
   logic [pdtm_pkg::ROM_IDX_W-1:0]  rom_idx;

   assign sel       = voice[SEL_W-1:0];
   assign cur_phase = phase_ff[sel];
   assign phase_sum = SUM_W'(cur_phase) + SUM_W'(step);
   assign int_part  = cur_phase[PHASE_W-1:PHASE_FRACTION_BITS];
   assign scaled    = {int_part, {pdtm_pkg::ROM_IDX_W{1'b0}}} >> INT_W;
   assign rom_idx   = scaled[pdtm_pkg::ROM_IDX_W-1:0];
   assign sample    = pdtm_pkg::SINE_ROM[rom_idx];

   always_comb begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (clear) begin
            phase_in[i] = '0;
         end else if (advance && (sel == SEL_W'(i))) begin
            phase_in[i] = phase_sum[PHASE_W-1:0];
         end else begin
            phase_in[i] = phase_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (reset) begin
            phase_ff[i] <= '0;
         end else begin
            phase_ff[i] <= phase_in[i];
         end
      end
   end

endmodule

### rtl/core/pdtm_ctrl.sv
// ----------------------------------------------------------------------------
// Tone mixer sequencer
// Steps the shared multiplier through the active voices, then through the
// divide by the voice count, and loads the output register.
// ----------------------------------------------------------------------------
module pdtm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              rsp_busy,
   input  logic [pdtm_pkg::COUNT_W-1:0]      n_active,
   output logic                              req_tready,
   output pdtm_pkg::ctl_type                 ctl
);

   pdtm_pkg::state_type              state_ff;
   pdtm_pkg::state_type              state_in;
   logic [pdtm_pkg::VOICE_W-1:0]     voice_ff;
   logic [pdtm_pkg::VOICE_W-1:0]     voice_in;
   logic                             last_voice;

   assign last_voice = (pdtm_pkg::COUNT_W'(voice_ff) + 3'd1) == n_active;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdtm_pkg::ST_IDLE;
         voice_ff <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      voice_in     = voice_ff;
      req_tready   = 1'b0;
      ctl          = '0;
      ctl.voice    = voice_ff;
      unique case (state_ff)
         pdtm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.accept  = 1'b1;
               ctl.acc_clr = 1'b1;
               voice_in    = '0;
               state_in    = pdtm_pkg::ST_MUL;
            end
         end
         pdtm_pkg::ST_MUL: begin
            ctl.mul_en  = 1'b1;
            ctl.advance = 1'b1;
            state_in    = pdtm_pkg::ST_ACC;
         end
         pdtm_pkg::ST_ACC: begin
            ctl.acc_en = 1'b1;
            if (last_voice) begin
               state_in = pdtm_pkg::ST_DIV;
            end else begin
               voice_in = voice_ff + 2'd1;
               state_in = pdtm_pkg::ST_MUL;
            end
         end
         pdtm_pkg::ST_DIV: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_div = 1'b1;
            state_in    = pdtm_pkg::ST_FIN;
         end
         pdtm_pkg::ST_FIN: begin
            if (!rsp_busy) begin
               ctl.out_load = 1'b1;
               state_in     = pdtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdtm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/polyphonic_dds_tone_mixer_top.sv
// ----------------------------------------------------------------------------
// Polyphonic tone mixer
// Mixes up to four sine voices read from a shared table into one PWM duty.
// ----------------------------------------------------------------------------
// Each beat on the req_ channel is one sample tick; bit 0 of req_tdata
// clears every voice phase before the tick. Each tick returns one beat on
// the rsp_ channel carrying the 8-bit duty value, 128 being silence.
// Voice count, phase steps and volumes are written through the csr_ port
// while no tick is in flight.
// For N active voices (1 to 4), the single shared multiplier takes each
// voice through a multiply state and an accumulate state, then multiplies
// by the reciprocal of N for the divide, and the FIN state forms the
// saturated result and loads it into the output register. A new tick is
// accepted only once the result sits in the output register, so no tick
// starts while another is being computed.
// Reset clears all phases and loads one voice, zero steps and unity
// volumes. If the receiver stalls, the result holds in the output register,
// one further tick is computed, and the block then waits until the output
// register is free.
// ----------------------------------------------------------------------------
module polyphonic_dds_tone_mixer_top #(
   parameter int MAX_VOICES          = 4,
   parameter int TABLE_ENTRIES       = 256,
   parameter int PHASE_FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // phase_clear, zero fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // duty_value
   input  logic                                 csr_wr_en,
   input  logic [pdtm_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [pdtm_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

`include "polyphonic_dds_tone_mixer_top_assert.svh"

   localparam int ACT_VOICES = (MAX_VOICES < pdtm_pkg::PACKED_VOICES) ?
                               MAX_VOICES : pdtm_pkg::PACKED_VOICES;

   logic [pdtm_pkg::COUNT_W-1:0]                   count_ff;
   logic [pdtm_pkg::PACKED_VOICES*pdtm_pkg::STEP_W-1:0] steps_ff;
   logic [pdtm_pkg::PACKED_VOICES*pdtm_pkg::VOL_W-1:0]  vols_ff;

   pdtm_pkg::ctl_type                      ctl;
   logic [pdtm_pkg::COUNT_W-1:0]           n_active;
   logic                                   rsp_busy;
   logic [pdtm_pkg::STEP_W-1:0]            step;
   logic [pdtm_pkg::VOL_W-1:0]             vol;
   logic [pdtm_pkg::SAMPLE_W-1:0]          sample;
   logic signed [8:0]                      centered;
   logic signed [pdtm_pkg::MUL_W-1:0]      op_a;
   logic signed [pdtm_pkg::MUL_W-1:0]      op_b;
   logic signed [pdtm_pkg::PROD_W-1:0]     product;
   logic signed [17:0]                     scaled;
   logic signed [17:0]                     rounded;
   logic signed [pdtm_pkg::ACC_W-1:0]      term;
   logic signed [pdtm_pkg::ACC_W-1:0]      acc_ff;
   logic signed [pdtm_pkg::ACC_W-1:0]      acc_in;
   logic [pdtm_pkg::ACC_W-1:0]             magnitude;
   logic [9:0]                             quotient;
   logic [11:0]                            mix;
   logic [7:0]                             duty;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [7:0]                             rsp_data_ff;
   logic [7:0]                             rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd1;
         steps_ff <= '0;
         vols_ff  <= 32'h8080_8080;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            pdtm_pkg::CSR_VOICE_COUNT:   count_ff <= csr_wr_data[pdtm_pkg::COUNT_W-1:0];
            pdtm_pkg::CSR_PHASE_STEPS:   steps_ff <= csr_wr_data;
            pdtm_pkg::CSR_VOICE_VOLUMES: vols_ff  <= csr_wr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (count_ff == 3'd0) begin
         n_active = 3'd1;
      end else if (count_ff > pdtm_pkg::COUNT_W'(ACT_VOICES)) begin
         n_active = pdtm_pkg::COUNT_W'(ACT_VOICES);
      end else begin
         n_active = count_ff;
      end
   end

   assign rsp_busy = rsp_valid_ff && !rsp_tready;

   pdtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_busy   (rsp_busy),
      .n_active   (n_active),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   assign step = steps_ff[ctl.voice*pdtm_pkg::STEP_W +: pdtm_pkg::STEP_W];
   assign vol  = vols_ff[ctl.voice*pdtm_pkg::VOL_W +: pdtm_pkg::VOL_W];

   pdtm_phase_bank #(
      .NUM_VOICES          (ACT_VOICES),
      .TABLE_ENTRIES       (TABLE_ENTRIES),
      .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
   ) u_phase_bank (
      .clock   (clock),
      .reset   (reset),
      .clear   (ctl.accept && req_tdata[0]),
      .advance (ctl.advance),
      .voice   (ctl.voice),
      .step    (step),
      .sample  (sample)
   );

   assign centered  = $signed({1'b0, sample}) - 9'sd128;
   assign magnitude = acc_ff[pdtm_pkg::ACC_W-1] ? -acc_ff : acc_ff;

   always_comb begin
      if (ctl.mul_div) begin
         op_a = $signed({2'b00, magnitude});
         op_b = $signed(pdtm_pkg::recip(n_active));
      end else begin
         op_a = {{4{centered[8]}}, centered};
         op_b = $signed({5'b00000, vol});
      end
   end

   pdtm_mul_unit u_mul (
      .clock     (clock),
      .enable    (ctl.mul_en),
      .operand_a (op_a),
      .operand_b (op_b),
      .product   (product)
   );

   // The voice term divides by 128 toward zero, so negative products are
   // biased before the arithmetic shift.
   assign scaled  = product[17:0];
   assign rounded = scaled + (scaled[17] ? 18'sd127 : 18'sd0);
   assign term    = rounded[17:7];

   always_comb begin
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign quotient = product[pdtm_pkg::RECIP_SHIFT+9:pdtm_pkg::RECIP_SHIFT];
   assign mix      = acc_ff[pdtm_pkg::ACC_W-1] ? 12'd128 - {2'b00, quotient}
                                               : 12'd128 + {2'b00, quotient};

   always_comb begin
      if (mix[11]) begin
         duty = 8'd0;
      end else if (mix > 12'd255) begin
         duty = 8'd255;
      end else begin
         duty = mix[7:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = duty;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PDTM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `PDTM_ASSERT_NEXT(a_acc_cleared, ctl.accept, acc_ff == '0)
   `PDTM_ASSERT_NEXT(a_load_shows_result, ctl.out_load, rsp_tvalid && rsp_tdata == $past(duty))
   `PDTM_ASSERT_SAME(a_load_only_free, ctl.out_load, !rsp_busy)

endmodule

### dv/tb_polyphonic_dds_tone_mixer_top.sv
// ----------------------------------------------------------------------------
// Tone mixer testbench
// Drives sample ticks into the tone mixer and checks every duty beat against
// a cycle-free mixer model kept in the bench. Directed tests cover reset
// defaults, saturation, volume and step extremes, voice count limits, held
// phases of inactive voices and phase clears. They are followed by random
// phases with fresh register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_polyphonic_dds_tone_mixer_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] SINE_LEVELS [256] = '{
      8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
      8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
      8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
      8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
      8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
      8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
      8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
      8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
      8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
      8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
      8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
      8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
      8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
      8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
      8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
      8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
      8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
      8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
      8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
      8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
      8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
      8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
      8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
      8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
      8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
      8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
      8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
      8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
      8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
      8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // phase_clear, zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // duty_value
   logic                  csr_wr_en = 1'b0;
   logic [pdtm_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [pdtm_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   logic [2:0]            cfg_voice_count = 3'd1;
   logic [63:0]           cfg_phase_steps = '0;
   logic [31:0]           cfg_voice_volumes = 32'h8080_8080;
   logic [15:0]           tone_phase [pdtm_pkg::PACKED_VOICES] = '{default: '0};

   logic [7:0]            expected_duty [$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    stall_left = 0;
   bit                    sender_idles = 1'b0;
   bit                    receiver_idles = 1'b0;

   polyphonic_dds_tone_mixer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] mix_next_duty(input logic clear_phase);
      int n;
      int sum;
      int mix;
      logic [7:0] level;
      n = int'(cfg_voice_count);
      if (n == 0) begin
         n = 1;
      end
      if (n > pdtm_pkg::PACKED_VOICES) begin
         n = pdtm_pkg::PACKED_VOICES;
      end
      if (clear_phase) begin
         for (int v = 0; v < pdtm_pkg::PACKED_VOICES; v++) begin
            tone_phase[v] = '0;
         end
      end
      sum = 0;
      for (int v = 0; v < n; v++) begin
         level = SINE_LEVELS[tone_phase[v][15:8]];
         sum += ((int'(level) - 128) * int'(cfg_voice_volumes[8*v +: 8])) / 128;
         tone_phase[v] = tone_phase[v] + cfg_phase_steps[16*v +: 16];
      end
      mix = sum / n + 128;
      if (mix < 0) begin
         mix = 0;
      end
      if (mix > 255) begin
         mix = 255;
      end
      return mix[7:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic write_reg(input pdtm_pkg::csr_addr_type idx, input logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         pdtm_pkg::CSR_VOICE_COUNT:   cfg_voice_count = value[2:0];
         pdtm_pkg::CSR_PHASE_STEPS:   cfg_phase_steps = value;
         pdtm_pkg::CSR_VOICE_VOLUMES: cfg_voice_volumes = value[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_tick(input logic clear_phase);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, clear_phase};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_duty.push_back(mix_next_duty(clear_phase));
      gap = 0;
      if (sender_idles && $urandom_range(0, 1) == 1) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_duty.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_polyphonic_dds_tone_mixer_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_duty.size() == 0) begin
            report_mismatch($sformatf("duty beat %0d with nothing expected", rsp_tdata));
         end else begin
            want = expected_duty.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch($sformatf("duty_value got %0d want %0d", rsp_tdata, want));
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
         stall_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_reset_defaults();
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
   endtask

   task automatic test_saturation();
      write_reg(pdtm_pkg::CSR_VOICE_COUNT, 64'd1);
      write_reg(pdtm_pkg::CSR_PHASE_STEPS, 64'h0000_0000_0000_4000);
      write_reg(pdtm_pkg::CSR_VOICE_VOLUMES, 64'h0000_0000_FFFF_FFFF);
      repeat (5) send_tick(1'b0);
      wait_idle();
      write_reg(pdtm_pkg::CSR_VOICE_VOLUMES, 64'h0000_0000_0000_0000);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_voice_count_limits();
      write_reg(pdtm_pkg::CSR_VOICE_VOLUMES, 64'h0000_0000_FF80_40FF);
      write_reg(pdtm_pkg::CSR_PHASE_STEPS, 64'h1234_0800_2A55_4000);
      write_reg(pdtm_pkg::CSR_VOICE_COUNT, 64'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
      // Voices 1 to 3 were idle, so their phases must still be at zero.
      write_reg(pdtm_pkg::CSR_VOICE_COUNT, 64'd4);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_idle();
      write_reg(pdtm_pkg::CSR_VOICE_COUNT, 64'd7);
      write_reg(pdtm_pkg::CSR_PHASE_STEPS, 64'hFFFF_FFFF_FFFF_FFFF);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
      write_reg(pdtm_pkg::CSR_VOICE_COUNT, 64'd4);
      write_reg(pdtm_pkg::CSR_PHASE_STEPS, 64'h4000_4000_4000_4000);
      write_reg(pdtm_pkg::CSR_VOICE_VOLUMES, 64'h0000_0000_FFFF_FFFF);
      repeat (4) send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_random_mixes(input int phases, input int ticks_per_phase);
      logic [2:0] count;
      logic [31:0] volumes;
      for (int p = 0; p < phases; p++) begin
         if ($urandom_range(0, 9) < 8) begin
            count = 3'($urandom_range(1, 4));
         end else begin
            count = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
         end
         case ($urandom_range(0, 5))
            0:       volumes = 32'h0000_0000;
            1:       volumes = 32'hFFFF_FFFF;
            2:       volumes = 32'h8080_8080;
            default: volumes = $urandom;
         endcase
         write_reg(pdtm_pkg::CSR_VOICE_COUNT, {61'b0, count});
         write_reg(pdtm_pkg::CSR_PHASE_STEPS, {$urandom, $urandom});
         write_reg(pdtm_pkg::CSR_VOICE_VOLUMES, {32'b0, volumes});
         sender_idles   = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         receiver_idles = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         for (int i = 0; i < ticks_per_phase; i++) begin
            send_tick($urandom_range(0, 11) == 0);
         end
         wait_idle();
      end
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_saturation();
      test_voice_count_limits();
      test_random_mixes(11, 50);
      if (mismatch_count == 0 && expected_duty.size() == 0) begin
         $display("tb_polyphonic_dds_tone_mixer_top OK");
      end else begin
         $display("tb_polyphonic_dds_tone_mixer_top NOT OK");
      end
      $finish;
   end

endmodule
